// ===== hdl/dtmf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtmf_pkg: shared types for the decode time max filter
// Operation codes of the shared compare unit and the history shift request.
// ----------------------------------------------------------------------------
package dtmf_pkg;

	localparam int unsigned DurW  = 16;
	localparam int unsigned TimeW = 32;

	typedef enum logic {
		OP_MAX = 1'b0,	// a < b
		OP_WIN = 1'b1	// (a - b) mod 2^32 < c
	} unit_op_t;

	typedef struct packed {
		logic             shift;
		logic [DurW-1:0]  max;
		logic [TimeW-1:0] stamp;
	} hist_req_t;

endpackage

// ===== hdl/dtmf_cmp.sv =====
// ----------------------------------------------------------------------------
// dtmf_cmp: shared subtract / compare unit
// One 32-bit subtractor and two unsigned less-than compares, shared by the check, merge and scan steps.
// ----------------------------------------------------------------------------
module dtmf_cmp (
	input  dtmf_pkg::unit_op_t          op,
	input  logic [dtmf_pkg::TimeW-1:0]  a,
	input  logic [dtmf_pkg::TimeW-1:0]  b,
	input  logic [dtmf_pkg::DurW-1:0]   c,
	output logic                        lt
);
	import dtmf_pkg::*;

	logic [TimeW-1:0] diff;

	assign diff = a - b;	// wraps mod 2^32

	always_comb begin
		unique case (op)
			OP_WIN:  lt = diff < {{(TimeW-DurW){1'b0}}, c};
			OP_MAX:  lt = a < b;
			default: lt = 1'b0;
		endcase
	end

endmodule

// ===== hdl/dtmf_hist.sv =====
// ----------------------------------------------------------------------------
// dtmf_hist: history shift line
// Slot 0 is the newest entry; a shift drops the oldest. One indexed read port.
// ----------------------------------------------------------------------------
module dtmf_hist #(
	parameter int unsigned HISTORY_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dtmf_pkg::hist_req_t                  req,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]     rd_idx,
	output logic [dtmf_pkg::DurW-1:0]            rd_max,
	output logic                                 rd_valid,
	output logic [dtmf_pkg::TimeW-1:0]           head_time,
	output logic                                 head_valid
);
	import dtmf_pkg::*;

	logic [DurW-1:0]          slot_max_q  [HISTORY_DEPTH];
	logic [TimeW-1:0]         slot_time_q [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] slot_vld_q;

	// valid bits only; slot payload is qualified by them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
		end else if (req.shift) begin
			slot_vld_q <= {slot_vld_q[HISTORY_DEPTH-2:0], 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (req.shift) begin
			slot_max_q[0]  <= req.max;
			slot_time_q[0] <= req.stamp;
			for (int k = 1; k < HISTORY_DEPTH; k++) begin
				slot_max_q[k]  <= slot_max_q[k-1];
				slot_time_q[k] <= slot_time_q[k-1];
			end
		end
	end

	assign rd_max     = slot_max_q[rd_idx];
	assign rd_valid   = slot_vld_q[rd_idx];
	assign head_time  = slot_time_q[0];
	assign head_valid = slot_vld_q[0];

`ifndef SYNTHESIS
	// valid slots always form a run starting at slot 0
	a_vld_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({1'b0, slot_vld_q} + {{HISTORY_DEPTH{1'b0}}, 1'b1}))
		else $error("history valid bits not a prefix run");

	a_shift_head: assert property (@(posedge clk) disable iff (!arst_n)
		req.shift |=> head_valid && head_time == $past(req.stamp))
		else $error("shift did not load newest slot");

	a_shift_age: assert property (@(posedge clk) disable iff (!arst_n)
		req.shift && slot_vld_q[0] |=> slot_max_q[1] == $past(slot_max_q[0]))
		else $error("history did not age by one slot");
`endif

endmodule

// ===== hdl/decode_time_max_filter.sv =====
// ----------------------------------------------------------------------------
// decode_time_max_filter: sliding window maximum of decode durations
// Merges samples into history slots by time and emits the running maximum.
// ----------------------------------------------------------------------------
//
//  channel  | signals                              | dir | notes
//  ---------+--------------------------------------+-----+------------------------
//  in       | in_valid in_ready decode_time_ms     | in  | one sample per request
//           | now_ms                               |     |
//  out      | out_valid out_ready filtered_max_ms  | out | one result per request
//  cfg      | cfg_wr_en cfg_wr_data                | in  | short_window_ms, no wait
//
//  Requests other than the first walk the slots (valid slots plus the empty
//  one that ends the walk, at most HISTORY_DEPTH) before the result is valid.
//  The first request after reset skips the walk and goes straight to
//  ST_DONE; its result is the held max, which reset clears.
//  The walk over the history goes through one shared compare unit, one slot
//  per cycle; in_ready is low while a request is being worked on.
//  A finished result sits in the output register; a new request is taken
//  while it waits, and the next result holds until out_ready frees it.
//  Reset clears control and valid bits and sets the window register to 1000 ms.
//
module decode_time_max_filter #(
	parameter int unsigned HISTORY_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample request
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] decode_time_ms,
	input  logic [31:0] now_ms,
	// result
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] filtered_max_ms,
	// window register
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import dtmf_pkg::*;

	localparam int unsigned IdxW = $clog2(HISTORY_DEPTH);
	localparam logic [DurW-1:0] WinReset = 16'd1000;

	typedef enum logic [2:0] {
		ST_IDLE,	// wait for a request
		ST_CHECK,	// distance to newest slot vs window
		ST_MERGE,	// raise running short max
		ST_SHIFT,	// open a new slot
		ST_SCAN,	// walk valid slots for the max
		ST_FIN,		// latch filtered max
		ST_DONE		// hand result to output register
	} state_t;

	state_t           state_q;
	logic             first_q;
	logic [DurW-1:0]  win_q;
	logic [DurW-1:0]  dur_q;
	logic [TimeW-1:0] now_q;
	logic [DurW-1:0]  rsm_q;	// running short max
	logic [DurW-1:0]  best_q;	// scan accumulator
	logic [DurW-1:0]  filt_q;	// held filtered max
	logic [IdxW-1:0]  idx_q;
	logic             out_valid_q;
	logic [DurW-1:0]  out_data_q;

	// shared unit hookup
	unit_op_t         u_op;
	logic [TimeW-1:0] u_a;
	logic [TimeW-1:0] u_b;
	logic             u_lt;

	hist_req_t        hreq;
	logic [DurW-1:0]  rd_max;
	logic             rd_valid;
	logic [TimeW-1:0] head_time;
	logic             head_valid;
	logic             idx_last;
	logic             out_free;

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign filtered_max_ms = out_data_q;
	assign idx_last        = (idx_q == IdxW'(HISTORY_DEPTH - 1));
	assign out_free        = !out_valid_q || out_ready;

	// operand select per step
	always_comb begin
		unique case (state_q)
			ST_CHECK: begin
				u_op = OP_WIN;
				u_a  = now_q;
				u_b  = head_time;
			end
			ST_MERGE: begin
				u_op = OP_MAX;
				u_a  = {{(TimeW-DurW){1'b0}}, rsm_q};
				u_b  = {{(TimeW-DurW){1'b0}}, dur_q};
			end
			ST_SCAN: begin
				u_op = OP_MAX;
				u_a  = {{(TimeW-DurW){1'b0}}, best_q};
				u_b  = {{(TimeW-DurW){1'b0}}, rd_max};
			end
			default: begin
				u_op = OP_MAX;
				u_a  = '0;
				u_b  = '0;
			end
		endcase
	end

	// new slot takes the short max, or this sample when nothing merged yet
	always_comb begin
		hreq.shift = (state_q == ST_SHIFT);
		hreq.max   = (rsm_q == '0) ? dur_q : rsm_q;
		hreq.stamp = now_q;
	end

	dtmf_cmp u_cmp (
		.op (u_op),
		.a  (u_a),
		.b  (u_b),
		.c  (win_q),
		.lt (u_lt)
	);

	dtmf_hist #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (hreq),
		.rd_idx     (idx_q),
		.rd_max     (rd_max),
		.rd_valid   (rd_valid),
		.head_time  (head_time),
		.head_valid (head_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WinReset;
		end else if (cfg_wr_en) begin
			win_q <= cfg_wr_data;
		end
	end

	// sample capture, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dur_q <= decode_time_ms;
			now_q <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b1;
			rsm_q       <= '0;
			best_q      <= '0;
			filt_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// a new result reloads the output register, else a taken one leaves
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						first_q <= 1'b0;
						state_q <= first_q ? ST_DONE : ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (head_valid && u_lt) ? ST_MERGE : ST_SHIFT;
				end
				ST_MERGE: begin
					if (u_lt) begin
						rsm_q  <= dur_q;
						best_q <= dur_q;
					end else begin
						best_q <= rsm_q;
					end
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SHIFT: begin
					rsm_q   <= '0;
					best_q  <= '0;
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_valid && u_lt) begin
						best_q <= rd_max;
					end
					if (!rd_valid || idx_last) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FIN: begin
					filt_q  <= best_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_data_q  <= filt_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while still busy");

	a_shift_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |=> rsm_q == '0)
		else $error("short max not cleared on new slot");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> out_valid && filtered_max_ms == $past(filt_q))
		else $error("result not loaded from filtered max");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && idx_last |=> state_q == ST_FIN)
		else $error("scan ran past last slot");
`endif

endmodule
